[sv/rc4_pkg.sv]
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, controller states and the command and status records
// that pass between the RC4 controller and its datapath.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int unsigned MAX_KEY_BYTES = 32;
  localparam int unsigned KEY_WORDS     = 4;
  localparam int unsigned KEY_WORD_W    = 64;
  localparam int unsigned KEY_BYTES     = KEY_WORDS * KEY_WORD_W / 8;
  localparam int unsigned KEY_IDX_W     = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int unsigned KEY_LEN_W     = 6;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = KEY_WORD_W;
  localparam int unsigned PERM_DEPTH    = 256;
  localparam int unsigned PERM_ADDR_W   = $clog2(PERM_DEPTH);
  localparam logic [PERM_ADDR_W-1:0] PERM_LAST = 8'hFF;
  localparam logic [KEY_LEN_W-1:0]   KEY_LEN_RESET = 6'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0    = 3'd0,
    REG_KEY1    = 3'd1,
    REG_KEY2    = 3'd2,
    REG_KEY3    = 3'd3,
    REG_KEY_LEN = 3'd4
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_KRD,
    ST_KRJ,
    ST_KWN,
    ST_KWJ,
    ST_PRD,
    ST_PRJ,
    ST_PWI,
    ST_PWJ,
    ST_POUT
  } rc4_state_e;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_FILL,
    DP_KRD,
    DP_KRJ,
    DP_KWN,
    DP_KWJ,
    DP_PRD,
    DP_PRJ,
    DP_PWI,
    DP_PWJ,
    DP_POUT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   load_in;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic last_entry;
  } dp_status_t;

endpackage

[sv/rc4_if.sv]
// ----------------------------------------------------------------------------
// rc4 stream interfaces
// Valid/ready channels for input bytes and result bytes.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_start;

  modport source (output valid, output data_byte, output message_start, input ready);
  modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

interface rc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, output result_byte, input ready);
  modport sink   (input valid, input result_byte, output ready);
endinterface

[sv/rc4_cfg_regs.sv]
// ----------------------------------------------------------------------------
// rc4_cfg_regs
// Key and key length registers, with the key length clamped for scheduling.
// ----------------------------------------------------------------------------
module rc4_cfg_regs (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          cfg_we_i,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]                 cfg_idx_i,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]                cfg_data_i,
  output logic [rc4_pkg::KEY_BYTES-1:0][7:0]            key_bytes_o,
  output logic [rc4_pkg::KEY_IDX_W-1:0]                 len_m1_o
);
  import rc4_pkg::*;

  logic [KEY_WORDS-1:0][KEY_WORD_W-1:0] key_q;
  logic [KEY_LEN_W-1:0]                 key_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      key_len_q <= KEY_LEN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY0:    key_q[0]  <= cfg_data_i;
        REG_KEY1:    key_q[1]  <= cfg_data_i;
        REG_KEY2:    key_q[2]  <= cfg_data_i;
        REG_KEY3:    key_q[3]  <= cfg_data_i;
        REG_KEY_LEN: key_len_q <= cfg_data_i[KEY_LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign key_bytes_o = key_q;

  // A zero length acts as one byte, anything too long is cut to the maximum.
  always_comb begin
    if (key_len_q == '0) begin
      len_m1_o = '0;
    end else if (key_len_q > KEY_LEN_W'(MAX_KEY_BYTES)) begin
      len_m1_o = KEY_IDX_W'(MAX_KEY_BYTES - 1);
    end else begin
      len_m1_o = KEY_IDX_W'(key_len_q - KEY_LEN_W'(1));
    end
  end

endmodule

[sv/rc4_ctrl.sv]
// ----------------------------------------------------------------------------
// rc4_ctrl
// Sequencer for key scheduling, keystream steps and the output register.
// ----------------------------------------------------------------------------
module rc4_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_start_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rc4_pkg::dp_cmd_t     cmd_o,
  input  rc4_pkg::dp_status_t  status_i
);
  import rc4_pkg::*;

  rc4_state_e state_q, state_d;
  logic       keyed_q, keyed_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      keyed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      keyed_q     <= keyed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    keyed_d      = keyed_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    in_ready_o   = 1'b0;
    cmd_o        = '{op: DP_NOP, load_in: 1'b0, load_out: 1'b0};
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = (in_start_i || !keyed_q) ? ST_FILL : ST_PRD;
        end
      end
      ST_FILL: begin
        cmd_o.op = DP_FILL;
        if (status_i.last_entry) state_d = ST_KRD;
      end
      ST_KRD: begin
        cmd_o.op = DP_KRD;
        state_d  = ST_KRJ;
      end
      ST_KRJ: begin
        cmd_o.op = DP_KRJ;
        state_d  = ST_KWN;
      end
      ST_KWN: begin
        cmd_o.op = DP_KWN;
        state_d  = ST_KWJ;
      end
      ST_KWJ: begin
        cmd_o.op = DP_KWJ;
        if (status_i.last_entry) begin
          keyed_d = 1'b1;
          state_d = ST_PRD;
        end else begin
          state_d = ST_KRD;
        end
      end
      ST_PRD: begin
        cmd_o.op = DP_PRD;
        state_d  = ST_PRJ;
      end
      ST_PRJ: begin
        cmd_o.op = DP_PRJ;
        state_d  = ST_PWI;
      end
      ST_PWI: begin
        cmd_o.op = DP_PWI;
        state_d  = ST_PWJ;
      end
      ST_PWJ: begin
        cmd_o.op = DP_PWJ;
        state_d  = ST_POUT;
      end
      ST_POUT: begin
        cmd_o.op = DP_POUT;
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/rc4_datapath.sv]
// ----------------------------------------------------------------------------
// rc4_datapath
// Permutation memory, indices, swap holding registers and the result byte.
// ----------------------------------------------------------------------------
module rc4_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  rc4_pkg::dp_cmd_t                     cmd_i,
  output rc4_pkg::dp_status_t                  status_o,
  input  logic [7:0]                           data_byte_i,
  input  logic [rc4_pkg::KEY_BYTES-1:0][7:0]   key_bytes_i,
  input  logic [rc4_pkg::KEY_IDX_W-1:0]        len_m1_i,
  output logic [7:0]                           result_byte_o
);
  import rc4_pkg::*;

  logic [7:0] mem [PERM_DEPTH];
  logic [7:0] rdata_q;
  logic       we;
  logic [PERM_ADDR_W-1:0] waddr, raddr;
  logic [7:0] wdata;

  logic [PERM_ADDR_W-1:0] n_q, n_d, i_q, i_d, j_q, j_d;
  logic [KEY_IDX_W-1:0]   kidx_q, kidx_d;
  logic [7:0] si_q, si_d, sj_q, sj_d, data_q, out_q;
  logic       byp_q, byp_d;
  logic [PERM_ADDR_W-1:0] mix_addr;

  // The read port is registered and returns the old word when it hits the
  // address being written in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  assign mix_addr = si_q + sj_q;

  always_comb begin
    we     = 1'b0;
    waddr  = n_q;
    wdata  = rdata_q;
    raddr  = mix_addr;
    n_d    = n_q;
    i_d    = i_q;
    j_d    = j_q;
    kidx_d = kidx_q;
    si_d   = si_q;
    sj_d   = sj_q;
    byp_d  = byp_q;
    case (cmd_i.op)
      DP_FILL: begin
        we     = 1'b1;
        wdata  = n_q;
        n_d    = n_q + 8'd1;
        i_d    = '0;
        j_d    = '0;
        kidx_d = '0;
      end
      DP_KRD: raddr = n_q;
      DP_KRJ: begin
        j_d   = j_q + rdata_q + key_bytes_i[kidx_q];
        si_d  = rdata_q;
        raddr = j_d;
      end
      DP_KWN: begin
        we    = 1'b1;
        waddr = n_q;
      end
      DP_KWJ: begin
        we     = 1'b1;
        waddr  = j_q;
        wdata  = si_q;
        n_d    = n_q + 8'd1;
        kidx_d = (kidx_q == len_m1_i) ? '0 : kidx_q + KEY_IDX_W'(1);
        // The schedule ends with both indices cleared.
        if (n_q == PERM_LAST) j_d = '0;
      end
      DP_PRD: begin
        i_d   = i_q + 8'd1;
        raddr = i_d;
      end
      DP_PRJ: begin
        j_d   = j_q + rdata_q;
        si_d  = rdata_q;
        raddr = j_d;
      end
      DP_PWI: begin
        we    = 1'b1;
        waddr = i_q;
        sj_d  = rdata_q;
      end
      DP_PWJ: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = si_q;
        // The read of S[si+sj] misses this write when it lands on j.
        byp_d = (mix_addr == j_q);
      end
      DP_POUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
      kidx_q <= '0;
    end else begin
      n_q    <= n_d;
      i_q    <= i_d;
      j_q    <= j_d;
      kidx_q <= kidx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    si_q  <= si_d;
    sj_q  <= sj_d;
    byp_q <= byp_d;
    if (cmd_i.load_in)  data_q <= data_byte_i;
    if (cmd_i.load_out) out_q  <= data_q ^ (byp_q ? si_q : rdata_q);
  end

  assign status_o.last_entry = (n_q == PERM_LAST);
  assign result_byte_o       = out_q;

endmodule

[sv/rc4_stream_cipher.sv]
// ----------------------------------------------------------------------------
// rc4_stream_cipher
// RC4 byte stream cipher with key registers and an on-chip permutation table.
// ----------------------------------------------------------------------------
// Input beats on in_i carry one data byte and a message_start flag; each one
// yields exactly one output beat on out_o holding the byte XORed with the
// next keystream byte. The key is loaded through the plain write port:
// indexes 0 to 3 hold key bytes 0 to 31 packed little-endian in 64-bit words,
// index 4 holds the key length (zero acts as one, above 32 acts as 32).
// Other indexes are ignored.
// A beat with message_start set, and the first beat after reset, starts a
// key schedule: all 256 entries of the table are filled with identity, then
// 256 steps scramble it. Each scrambling step runs through KRD, KRJ, KWN
// and KWJ: a read of S[n], a read of S[j] and two writes for the swap, on a
// table with one read port and one write port.
// A keystream byte passes from the accepting edge through PRD, which steps
// i and reads S[i], PRJ, which moves j and reads S[j], PWI and PWJ for the
// two swap writes, the second with the mix read, and POUT, which loads the
// result once the output register is free. A beat is taken only while the
// sequencer is idle, so the next byte waits until this one is loaded.
// The output register holds a result while the receiver stalls, and a new
// input beat can be accepted meanwhile; its result waits for the register.
// Reset clears the indices and the key registers (key length 16); the table
// holds no valid contents until the first schedule.
// ----------------------------------------------------------------------------
module rc4_stream_cipher (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  rc4_in_if.sink                             in_i,
  rc4_out_if.source                          out_o,
  input  logic                               cfg_we_i,
  input  logic [rc4_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import rc4_pkg::*;

  dp_cmd_t                    cmd;
  dp_status_t                 status;
  logic [KEY_BYTES-1:0][7:0]  key_bytes;
  logic [KEY_IDX_W-1:0]       len_m1;

  rc4_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .key_bytes_o (key_bytes),
    .len_m1_o    (len_m1)
  );

  // The sequencer owns every handshake; the datapath only follows commands.
  rc4_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_start_i  (in_i.message_start),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  rc4_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .data_byte_i   (in_i.data_byte),
    .key_bytes_i   (key_bytes),
    .len_m1_i      (len_m1),
    .result_byte_o (out_o.result_byte)
  );

endmodule

[sv/rc4_checker.sv]
// ----------------------------------------------------------------------------
// rc4_checker
// Port-level checks for the RC4 cipher, bound to the top level.
// ----------------------------------------------------------------------------
module rc4_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] result_byte_i
);

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  // A result waits for the receiver.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  // The input is not ready again directly after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_i)
    else $error("input taken again right after an accept");

  // Even without a key schedule a result passes through the keystream states first.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_fire, 1) && !$past(in_fire, 2) && !$past(in_fire, 3))
    else $error("result appeared too soon after an accept");

  // A new result cannot overwrite one still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(result_byte_i))
    else $error("waiting result changed");

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .result_byte_i (out_o.result_byte)
);

[tb/sv/rc4_stream_cipher_tb.sv]
// ----------------------------------------------------------------------------
// rc4_stream_cipher_tb
// Self-checking testbench for the RC4 stream cipher. A behavioral copy of
// the cipher predicts every output byte from the accepted input beats and
// the key registers. Directed tests cover the first beat after reset, key
// length corner values, ignored register indexes and key changes in the
// middle of a message. They are followed by a long run of random messages
// with random pacing on both channels.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rc4_pkg::*;

  // Longest pause, in cycles, that either side puts in front of a beat.
  localparam int unsigned MAX_IDLE = 7;
  // During a key schedule no beat is taken on the input channel.
  // The limit covers one schedule many times over.
  localparam int unsigned STALL_LIMIT = 20000;
  // Cycles that pass after the last expected byte before the key registers
  // are touched, and before the run is closed.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RANDOM_ITEMS = 750;
  localparam int unsigned MAX_PRINTED = 40;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  rc4_in_if in_if ();
  rc4_out_if out_if ();

  rc4_stream_cipher dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Free-running clock with a 2 ns period.
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Behavioral copy of the cipher. It keeps its own permutation table,
  // indices and key registers, and is stepped once per accepted input beat.
  // --------------------------------------------------------------------------
  logic [7:0] sbox [PERM_DEPTH];
  logic [7:0] ks_i;
  logic [7:0] ks_j;
  bit keyed;
  logic [KEY_WORD_W-1:0] key_word [KEY_WORDS];
  logic [KEY_LEN_W-1:0] key_len;

  // Output bytes that the block still owes, oldest first.
  logic [7:0] expected_bytes [$];

  // Run bookkeeping.
  int unsigned n_errors;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_schedules;
  int unsigned n_cfg_writes;
  int unsigned quiet_cycles;

  // When clear, both channels run without pauses.
  bit idle_on;

  function automatic logic [7:0] key_byte_at(int unsigned n);
    return key_word[n / 8][8 * (n % 8) +: 8];
  endfunction

  // Key scheduling: identity fill, then one scrambling pass over the table
  // with the key bytes cycled at the effective key length.
  function automatic void schedule_key();
    int unsigned len;
    logic [7:0] j;
    logic [7:0] t;
    len = key_len;
    // A zero length acts as one byte, anything above the maximum saturates.
    if (len == 0) len = 1;
    if (len > MAX_KEY_BYTES) len = MAX_KEY_BYTES;
    for (int n = 0; n < PERM_DEPTH; n++) sbox[n] = 8'(n);
    j = '0;
    for (int n = 0; n < PERM_DEPTH; n++) begin
      j = j + sbox[n] + key_byte_at(n % len);
      t = sbox[n];
      sbox[n] = sbox[j];
      sbox[j] = t;
    end
    ks_i = '0;
    ks_j = '0;
    keyed = 1'b1;
    n_schedules++;
  endfunction

  // One keystream step applied to a data byte. The first beat after reset
  // schedules the key whatever its start flag says.
  function automatic logic [7:0] cipher_byte(logic [7:0] data, logic start);
    logic [7:0] si;
    logic [7:0] sj;
    if (start || !keyed) schedule_key();
    ks_i = ks_i + 8'd1;
    ks_j = ks_j + sbox[ks_i];
    si = sbox[ks_i];
    sj = sbox[ks_j];
    sbox[ks_i] = sj;
    sbox[ks_j] = si;
    return data ^ sbox[8'(si + sj)];
  endfunction

  function automatic int unsigned draw_idle();
    return idle_on ? $urandom_range(0, MAX_IDLE) : 0;
  endfunction

  task automatic report_mismatch(input string msg);
    n_errors++;
    if (n_errors <= MAX_PRINTED) $display("tb: mismatch: %s", msg);
  endtask

  // --------------------------------------------------------------------------
  // Driving helpers. Every task is entered and left at a rising clock edge,
  // so each input changes by one nonblocking assignment per time step.
  // --------------------------------------------------------------------------

  // Writes one register and mirrors the write in the behavioral copy.
  // Indexes past the key length register are ignored by the block.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_word[idx] = value;
      REG_KEY_LEN: key_len = value[KEY_LEN_W-1:0];
      default: ;
    endcase
    n_cfg_writes++;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Sends one beat after a random pause. Valid is left high after the
  // handshake; the next call either moves straight to a new beat or lowers
  // valid for its pause, so valid never drops and rises in the same step.
  task automatic send_byte(input logic [7:0] data, input logic start);
    int unsigned gap;
    gap = draw_idle();
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data_byte <= data;
    in_if.message_start <= start;
    // Valid was high through the cycle, so ready seen at an edge means the
    // beat was taken at that edge.
    do @(posedge clk_i); while (!in_if.ready);
    expected_bytes.push_back(cipher_byte(data, start));
    n_sent++;
  endtask

  // Stops sending and waits until every owed byte has come back and the
  // sequencer has had time to settle. Key writes happen only after this.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [KEY_WORD_W-1:0] random_key_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_key_len();
    case ($urandom_range(0, 7))
      0: return CFG_DATA_W'(0);
      1: return CFG_DATA_W'(1);
      2: return CFG_DATA_W'(MAX_KEY_BYTES);
      3: return CFG_DATA_W'((1 << KEY_LEN_W) - 1);
      4: return CFG_DATA_W'($urandom_range(1, 5));
      // Upper bits beyond the length field must be dropped by the block.
      5: return {$urandom, $urandom};
      default: return CFG_DATA_W'($urandom_range(0, (1 << KEY_LEN_W) - 1));
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Result side: the ready pacing and the checker.
  // --------------------------------------------------------------------------

  // Before each output beat the receiver holds ready low for a random
  // number of cycles, then keeps it high until a beat is taken.
  initial begin : result_pacing
    int unsigned hold;
    out_if.ready <= 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      hold = draw_idle();
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
    end
  end

  // Every output beat is compared with the oldest owed byte.
  always @(posedge clk_i) begin
    logic [7:0] want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected output byte %02h", out_if.result_byte));
      end else begin
        want = expected_bytes.pop_front();
        n_checked++;
        if (out_if.result_byte !== want) begin
          report_mismatch($sformatf("result_byte %02h, expected %02h (output beat %0d)",
                                    out_if.result_byte, want, n_checked));
        end
      end
    end
  end

  // Watchdog: cycles with no beat on either channel. A key schedule is the
  // longest quiet stretch a correct block produces.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: watchdog expired after %0d quiet cycles", quiet_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests.
  // --------------------------------------------------------------------------

  // The first beat after reset must schedule the reset key (all zero bytes,
  // length 16) even though its start flag is clear. Data extremes ride along.
  task automatic test_first_beat_after_reset();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    // A fresh start on the same key must rewind the keystream.
    send_byte(8'h5A, 1'b1);
  endtask

  // Zero length acts as one, lengths past the maximum saturate, and the
  // maximum uses all four key words.
  task automatic test_key_length_corners();
    logic [CFG_DATA_W-1:0] lens [5];
    lens = '{CFG_DATA_W'(0), CFG_DATA_W'(1), CFG_DATA_W'(MAX_KEY_BYTES),
             CFG_DATA_W'(MAX_KEY_BYTES + 1), CFG_DATA_W'((1 << KEY_LEN_W) - 1)};
    wait_idle();
    write_register(REG_KEY0, '1);
    write_register(REG_KEY1, {$urandom, $urandom});
    write_register(REG_KEY2, '0);
    write_register(REG_KEY3, {$urandom, $urandom});
    foreach (lens[k]) begin
      wait_idle();
      write_register(REG_KEY_LEN, lens[k]);
      send_byte(8'($urandom), 1'b1);
      send_byte(8'($urandom), 1'b0);
    end
  endtask

  // Writes to indexes that hold no register must leave the key untouched.
  task automatic test_unused_indexes();
    wait_idle();
    write_register(REG_KEY_LEN, CFG_DATA_W'(7));
    for (int k = int'(REG_KEY_LEN) + 1; k < (1 << CFG_IDX_W); k++) begin
      write_register(CFG_IDX_W'(k), {$urandom, $urandom});
    end
    send_byte(8'($urandom), 1'b1);
    send_byte(8'($urandom), 1'b0);
  endtask

  // New key values written in the middle of a message only take effect at
  // the next start; the bytes in between keep the old keystream.
  task automatic test_key_change_mid_message();
    wait_idle();
    write_register(REG_KEY0, {$urandom, $urandom});
    write_register(REG_KEY_LEN, CFG_DATA_W'(5));
    send_byte(8'($urandom), 1'b1);
    send_byte(8'($urandom), 1'b0);
    wait_idle();
    write_register(REG_KEY0, {$urandom, $urandom});
    write_register(REG_KEY_LEN, CFG_DATA_W'(3));
    send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
  endtask

  // Random messages: mostly a start beat followed by a run of data, with an
  // occasional stray start inside a message and occasional continuations
  // across a key change. Pacing switches between random pauses and bursts.
  task automatic test_random_messages();
    int unsigned target;
    int unsigned msg_len;
    logic fresh;
    target = n_sent + RANDOM_ITEMS;
    while (n_sent < target) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        if ($urandom_range(0, 1) != 0) write_register(REG_KEY0, random_key_word());
        if ($urandom_range(0, 1) != 0) write_register(REG_KEY1, random_key_word());
        if ($urandom_range(0, 1) != 0) write_register(REG_KEY2, random_key_word());
        if ($urandom_range(0, 1) != 0) write_register(REG_KEY3, random_key_word());
        if ($urandom_range(0, 1) != 0) write_register(REG_KEY_LEN, random_key_len());
        if ($urandom_range(0, 7) == 0) begin
          write_register(CFG_IDX_W'($urandom_range(int'(REG_KEY_LEN) + 1,
                                                   (1 << CFG_IDX_W) - 1)),
                         {$urandom, $urandom});
        end
      end
      msg_len = $urandom_range(1, 40);
      fresh = ($urandom_range(0, 7) != 0);
      for (int k = 0; k < msg_len; k++) begin
        send_byte(8'($urandom), (k == 0) ? fresh : ($urandom_range(0, 31) == 0));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= REG_KEY0;
    cfg_data_i <= '0;
    in_if.valid <= 1'b0;
    in_if.data_byte <= '0;
    in_if.message_start <= 1'b0;

    // Reset state of the behavioral copy.
    foreach (sbox[n]) sbox[n] = '0;
    ks_i = '0;
    ks_j = '0;
    keyed = 1'b0;
    foreach (key_word[n]) key_word[n] = '0;
    key_len = KEY_LEN_RESET;
    n_errors = 0;
    n_sent = 0;
    n_checked = 0;
    n_schedules = 0;
    n_cfg_writes = 0;
    idle_on = 1'b1;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_first_beat_after_reset();
    test_key_length_corners();
    test_unused_indexes();
    test_key_change_mid_message();
    test_random_messages();

    // Drain; the watchdog ends the run if the block stops answering.
    wait_idle();
    if (expected_bytes.size() != 0) begin
      report_mismatch($sformatf("%0d output bytes never arrived", expected_bytes.size()));
    end

    $display("tb: %0d beats sent, %0d output bytes checked, %0d mismatches",
             n_sent, n_checked, n_errors);
    $display("tb: %0d key schedules, %0d register writes", n_schedules, n_cfg_writes);
    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
